// ===== src/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants, types and register codes of the separable Gaussian blur.
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_RADIUS = 4;
	localparam int RING       = 2 * MAX_RADIUS;
	localparam int TAPS       = 2 * MAX_RADIUS + 1;
	localparam int NPAIR      = MAX_RADIUS + 1;

	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int HW     = 13;
	localparam int ROWW   = HW + 1;
	localparam int RW     = $clog2(MAX_RADIUS + 1);
	localparam int SLOTW  = $clog2(RING);
	localparam int HIDXW  = $clog2(TAPS);
	localparam int WGTW   = 16;
	localparam int FRAC   = 16;
	localparam int PSW    = 9;

	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int PADDRW = 5;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_BLUR_RADIUS  = 3'd2,
		REG_COEF_CENTER  = 3'd3,
		REG_COEF_1       = 3'd4,
		REG_COEF_2       = 3'd5,
		REG_COEF_3       = 3'd6,
		REG_COEF_4       = 3'd7
	} reg_idx_t;

	// Channel 2 is red, 1 green, 0 blue.
	typedef logic [2:0][7:0] rgb_t;

	typedef logic [NPAIR-1:0][PSW-1:0]  psum_t;
	typedef logic [NPAIR-1:0][WGTW-1:0] wgt_t;

	typedef struct packed {
		logic [11:0] frame_width;
		logic [12:0] frame_height;
		logic [2:0]  blur_radius;
		wgt_t        coef;
	} cfg_t;

	typedef struct packed {
		rgb_t                          pix;
		logic [XW-1:0]                 x;
		logic                          wr;
		logic [SLOTW-1:0]              wslot;
		logic                          vert;
		logic [NPAIR-1:0][SLOTW-1:0]   vslot_up;
		logic [NPAIR-1:0][SLOTW-1:0]   vslot_dn;
		logic [NPAIR-1:0]              vpix_up;
		logic [NPAIR-1:0]              vpix_dn;
		logic                          emit;
		logic                          pass;
		logic                          frame_end;
		logic [RW-1:0]                 radius;
		logic [NPAIR-1:0][HIDXW-1:0]   hidx_up;
		logic [NPAIR-1:0][HIDXW-1:0]   hidx_dn;
	} cmd_t;

	typedef struct packed {
		logic [QCW-1:0] count;
		logic           full;
		logic           empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== src/sgb_if.sv =====
// ----------------------------------------------------------------------------
// sgb_if
// Valid/ready channels for input pixels and blurred output pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgb_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, kind, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface sgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end;

	modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/separable_gaussian_blur_rgb_top.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb_top
// Separable Gaussian blur of an RGB raster stream with APB configuration.
// ----------------------------------------------------------------------------
//   channel   dir   beat contents
//   px_in     in    kind, red_in, green_in, blue_in
//   px_out    out   red_out, green_out, blue_out, frame_end
//   apb       in    register writes and reads, byte address 4*index
//
// One beat per clock sustained while the output is not stalled: the back retires one command every unstalled clock.
// With the queue empty, a result is presented once its input beat has passed
// through the queue, the registered line RAM read, two three-stage multiply-add
// pipelines, the window shift and the output register.
// Line RAM contents are not cleared after reset.
// A stalled output register freezes the back; the four-entry command queue
// keeps taking beats until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_gaussian_blur_rgb_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sgb_pkg::PADDRW-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	sgb_in_if.sink                           px_in,
	sgb_out_if.source                        px_out
);

	sgb_pkg::cfg_t      cfg_q;
	sgb_pkg::reg_idx_t  idx;
	sgb_pkg::cmd_t      push_cmd, head;
	sgb_pkg::q_status_t q_stat;
	logic               q_push, q_pop, wr_en;

	assign pready = 1'b1;
	assign idx    = sgb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= 12'd640;
			cfg_q.frame_height <= 13'd480;
			cfg_q.blur_radius  <= 3'd0;
			// Only the center weight is nonzero after reset.
			cfg_q.coef         <= sgb_pkg::wgt_t'(16'hFFFF);
		end else if (wr_en) begin
			unique case (idx)
				sgb_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[11:0];
				sgb_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[12:0];
				sgb_pkg::REG_BLUR_RADIUS:  cfg_q.blur_radius  <= pwdata[2:0];
				sgb_pkg::REG_COEF_CENTER:  cfg_q.coef[0]      <= pwdata[15:0];
				sgb_pkg::REG_COEF_1:       cfg_q.coef[1]      <= pwdata[15:0];
				sgb_pkg::REG_COEF_2:       cfg_q.coef[2]      <= pwdata[15:0];
				sgb_pkg::REG_COEF_3:       cfg_q.coef[3]      <= pwdata[15:0];
				sgb_pkg::REG_COEF_4:       cfg_q.coef[4]      <= pwdata[15:0];
				default:                   cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sgb_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_q.frame_width);
			sgb_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
			sgb_pkg::REG_BLUR_RADIUS:  prdata = 32'(cfg_q.blur_radius);
			sgb_pkg::REG_COEF_CENTER:  prdata = 32'(cfg_q.coef[0]);
			sgb_pkg::REG_COEF_1:       prdata = 32'(cfg_q.coef[1]);
			sgb_pkg::REG_COEF_2:       prdata = 32'(cfg_q.coef[2]);
			sgb_pkg::REG_COEF_3:       prdata = 32'(cfg_q.coef[3]);
			sgb_pkg::REG_COEF_4:       prdata = 32'(cfg_q.coef[4]);
			default:                   prdata = '0;
		endcase
	end

	sgb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.px_in  (px_in),
		.q_full (q_stat.full),
		.push   (q_push),
		.cmd    (push_cmd)
	);

	sgb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head),
		.status   (q_stat)
	);

	sgb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head),
		.q_empty (q_stat.empty),
		.pop     (q_pop),
		.px_out  (px_out)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("command queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= sgb_pkg::QCW'(sgb_pkg::QDEPTH))
		else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== src/sgb_ram.sv =====
// ----------------------------------------------------------------------------
// sgb_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     ren,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ren) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== src/sgb_filter.sv =====
// ----------------------------------------------------------------------------
// sgb_filter
// One channel of a symmetric kernel: multiply pair sums, add, truncate, clip.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_filter (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire sgb_pkg::psum_t psum,
	input  wire sgb_pkg::wgt_t  wgt,
	output logic [7:0]         res
);

	localparam int PRW   = sgb_pkg::PSW + sgb_pkg::WGTW;
	localparam int NPART = (sgb_pkg::NPAIR + 1) / 2;
	localparam int ACCW  = PRW + 1 + $clog2(NPART + 1);
	localparam int HIW   = ACCW - sgb_pkg::FRAC;

	logic [PRW-1:0]  prod_s1 [sgb_pkg::NPAIR];
	logic [PRW:0]    part_s2 [NPART];
	logic [ACCW-1:0] acc;
	logic [HIW-1:0]  hi;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sgb_pkg::NPAIR; k++) begin
				prod_s1[k] <= PRW'(psum[k]) * PRW'(wgt[k]);
			end
			for (int j = 0; j < NPART; j++) begin
				if (2 * j + 1 < sgb_pkg::NPAIR) begin
					part_s2[j] <= {1'b0, prod_s1[2*j]} + {1'b0, prod_s1[2*j+1]};
				end else begin
					part_s2[j] <= {1'b0, prod_s1[2*j]};
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int j = 0; j < NPART; j++) begin
			acc = acc + ACCW'(part_s2[j]);
		end
		hi  = acc[ACCW-1:sgb_pkg::FRAC];
		res = (hi > HIW'(255)) ? 8'hFF : hi[7:0];
	end

endmodule

`default_nettype wire

// ===== src/sgb_queue.sv =====
// ----------------------------------------------------------------------------
// sgb_queue
// Short command queue between the classifying front and the filter back.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire sgb_pkg::cmd_t      push_cmd,
	input  wire logic               pop,
	output sgb_pkg::cmd_t           head,
	output sgb_pkg::q_status_t      status
);

	sgb_pkg::cmd_t                  mem_q [sgb_pkg::QDEPTH];
	logic [sgb_pkg::QPW-1:0]        wptr_q;
	logic [sgb_pkg::QPW-1:0]        rptr_q;
	logic [sgb_pkg::QCW-1:0]        count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = mem_q[rptr_q];
	assign status.count = count_q;
	assign status.full  = (count_q == sgb_pkg::QCW'(sgb_pkg::QDEPTH));
	assign status.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== src/sgb_front.sv =====
// ----------------------------------------------------------------------------
// sgb_front
// Accepts beats, tracks frame position and turns each beat into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sgb_pkg::cfg_t cfg,
	sgb_in_if.sink             px_in,
	input  wire logic          q_full,
	output logic               push,
	output sgb_pkg::cmd_t      cmd
);

	localparam int XW   = sgb_pkg::XW;
	localparam int HW   = sgb_pkg::HW;
	localparam int ROWW = sgb_pkg::ROWW;
	localparam int RW   = sgb_pkg::RW;
	localparam int HXW  = sgb_pkg::HIDXW;

	logic [ROWW-1:0] in_row_q;
	logic [XW-1:0]   in_col_q;
	logic [RW-1:0]   vcnt_q;
	logic [XW-1:0]   oc_q;
	logic [HW-1:0]   orow_q;
	logic [XW-1:0]   act_wm1_q;
	logic [HW-1:0]   act_hm1_q;
	logic [RW-1:0]   act_r_q;

	logic            accept, latch, real_px, drop, pass, vert, emit, fend;
	logic [XW-1:0]   wm1_reg, wm1;
	logic [HW-1:0]   hm1_reg, hm1;
	logic [RW-1:0]   r_reg, r;
	logic [ROWW-1:0] y, up_t, dn_t;
	logic [ROWW:0]   dn_s;
	logic [XW-1:0]   rem, m_up, m_dn;

	assign px_in.ready = !q_full;
	assign accept      = px_in.valid && px_in.ready;

	always_comb begin
		if (cfg.frame_width == '0) begin
			wm1_reg = '0;
		end else if (cfg.frame_width > 12'(sgb_pkg::MAX_WIDTH)) begin
			wm1_reg = XW'(sgb_pkg::MAX_WIDTH - 1);
		end else begin
			wm1_reg = XW'(cfg.frame_width - 12'd1);
		end
		hm1_reg = (cfg.frame_height == '0) ? '0 : cfg.frame_height - 13'd1;
		r_reg   = (cfg.blur_radius > 3'(sgb_pkg::MAX_RADIUS)) ?
			RW'(sgb_pkg::MAX_RADIUS) : RW'(cfg.blur_radius);

		// Geometry is taken from the registers on the first pixel of a frame.
		latch = !px_in.kind && (in_row_q == '0) && (in_col_q == '0);
		wm1   = latch ? wm1_reg : act_wm1_q;
		hm1   = latch ? hm1_reg : act_hm1_q;
		r     = latch ? r_reg   : act_r_q;

		real_px = (in_row_q <= ROWW'(hm1));
		pass    = (r == '0);
		drop    = (real_px && px_in.kind) || (!real_px && pass);
		vert    = !pass && (in_row_q >= ROWW'(r));
		emit    = pass || (vert && (vcnt_q >= r));
		if (pass) begin
			fend = (in_row_q == ROWW'(hm1)) && (in_col_q == wm1);
		end else begin
			fend = emit && (orow_q == hm1) && (oc_q == wm1);
		end

		y   = in_row_q - ROWW'(r);
		rem = wm1 - oc_q;

		cmd.pix       = {px_in.red_in, px_in.green_in, px_in.blue_in};
		cmd.x         = in_col_q;
		cmd.wr        = real_px && !pass;
		cmd.wslot     = in_row_q[sgb_pkg::SLOTW-1:0];
		cmd.vert      = vert;
		cmd.emit      = emit;
		cmd.pass      = pass;
		cmd.frame_end = fend;
		cmd.radius    = r;

		for (int k = 0; k < sgb_pkg::NPAIR; k++) begin
			up_t = (y >= ROWW'(k)) ? y - ROWW'(k) : '0;
			dn_s = (ROWW+1)'(y) + (ROWW+1)'(k);
			dn_t = (dn_s > (ROWW+1)'(hm1)) ? ROWW'(hm1) : dn_s[ROWW-1:0];
			cmd.vslot_up[k] = up_t[sgb_pkg::SLOTW-1:0];
			cmd.vslot_dn[k] = dn_t[sgb_pkg::SLOTW-1:0];
			cmd.vpix_up[k]  = real_px && (up_t == in_row_q);
			cmd.vpix_dn[k]  = real_px && (dn_t == in_row_q);

			// Window index of a horizontal tap, clamped at the row edges.
			m_up = (XW'(k) < oc_q) ? XW'(k) : oc_q;
			m_dn = (XW'(k) < rem) ? XW'(k) : rem;
			if (RW'(k) > r) begin
				cmd.hidx_up[k] = '0;
				cmd.hidx_dn[k] = '0;
			end else begin
				cmd.hidx_up[k] = HXW'(r) + HXW'(m_up);
				cmd.hidx_dn[k] = HXW'(r) - HXW'(m_dn);
			end
		end

		push = accept && !drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			vcnt_q    <= '0;
			oc_q      <= '0;
			orow_q    <= '0;
			act_wm1_q <= XW'(639);
			act_hm1_q <= HW'(479);
			act_r_q   <= '0;
		end else if (push) begin
			if (latch) begin
				act_wm1_q <= wm1_reg;
				act_hm1_q <= hm1_reg;
				act_r_q   <= r_reg;
			end
			if (fend) begin
				in_row_q <= '0;
				in_col_q <= '0;
				vcnt_q   <= '0;
				oc_q     <= '0;
				orow_q   <= '0;
			end else begin
				if (in_col_q == wm1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (vert && (vcnt_q < RW'(sgb_pkg::MAX_RADIUS))) begin
					vcnt_q <= vcnt_q + 1'b1;
				end
				if (emit && !pass) begin
					if (oc_q == wm1) begin
						oc_q   <= '0;
						orow_q <= orow_q + 1'b1;
					end else begin
						oc_q <= oc_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/sgb_back.sv =====
// ----------------------------------------------------------------------------
// sgb_back
// Line buffers, vertical pass, column window, horizontal pass and output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sgb_pkg::cfg_t      cfg,
	input  wire sgb_pkg::cmd_t      head,
	input  wire logic               q_empty,
	output logic                    pop,
	sgb_out_if.source               px_out
);

	localparam int NP = sgb_pkg::NPAIR;

	logic                 en;
	sgb_pkg::rgb_t        rd [sgb_pkg::RING];
	sgb_pkg::rgb_t        win_q [sgb_pkg::TAPS];
	sgb_pkg::rgb_t        vres, hres;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	sgb_pkg::cmd_t        cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7, cmd_s8;
	sgb_pkg::psum_t       vps_s2 [3];
	sgb_pkg::psum_t       hps_s6 [3];
	sgb_pkg::wgt_t        wv, wh;

	logic                 out_valid_q;
	sgb_pkg::rgb_t        out_pix_q;
	logic                 out_fend_q;

	function automatic sgb_pkg::psum_t vps_tap(input int c);
		sgb_pkg::psum_t ps;
		sgb_pkg::rgb_t  u, d;
		for (int k = 0; k < NP; k++) begin
			u = cmd_s1.vpix_up[k] ? cmd_s1.pix : rd[cmd_s1.vslot_up[k]];
			d = cmd_s1.vpix_dn[k] ? cmd_s1.pix : rd[cmd_s1.vslot_dn[k]];
			if (k == 0) begin
				ps[k] = {1'b0, u[c]};
			end else begin
				ps[k] = {1'b0, u[c]} + {1'b0, d[c]};
			end
		end
		return ps;
	endfunction

	function automatic sgb_pkg::psum_t hps_tap(input int c);
		sgb_pkg::psum_t ps;
		sgb_pkg::rgb_t  u, d;
		for (int k = 0; k < NP; k++) begin
			u = win_q[cmd_s5.hidx_up[k]];
			d = win_q[cmd_s5.hidx_dn[k]];
			if (k == 0) begin
				ps[k] = {1'b0, u[c]};
			end else begin
				ps[k] = {1'b0, u[c]} + {1'b0, d[c]};
			end
		end
		return ps;
	endfunction

	// The whole back moves together; it stops only while a beat waits at the output.
	assign en  = !out_valid_q || px_out.ready;
	assign pop = en && !q_empty;

	for (genvar i = 0; i < sgb_pkg::RING; i++) begin : g_line
		sgb_ram #(
			.WIDTH (24),
			.DEPTH (sgb_pkg::MAX_WIDTH)
		) u_line (
			.clk   (clk),
			.we    (pop && head.wr && (head.wslot == sgb_pkg::SLOTW'(i))),
			.waddr (head.x),
			.wdata (head.pix),
			.ren   (en),
			.raddr (head.x),
			.rdata (rd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			for (int j = 0; j < sgb_pkg::TAPS; j++) begin
				win_q[j] <= '0;
			end
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			if (v_s4 && cmd_s4.vert) begin
				for (int j = sgb_pkg::TAPS - 1; j > 0; j--) begin
					win_q[j] <= win_q[j-1];
				end
				win_q[0] <= vres;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= head;
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
			cmd_s4 <= cmd_s3;
			cmd_s5 <= cmd_s4;
			cmd_s6 <= cmd_s5;
			cmd_s7 <= cmd_s6;
			cmd_s8 <= cmd_s7;
			for (int c = 0; c < 3; c++) begin
				vps_s2[c] <= vps_tap(c);
				hps_s6[c] <= hps_tap(c);
			end
		end
	end

	// Taps beyond the radius carry whatever; their weight is forced to zero.
	always_comb begin
		for (int k = 0; k < NP; k++) begin
			wv[k] = (sgb_pkg::RW'(k) <= cmd_s2.radius) ? cfg.coef[k] : '0;
			wh[k] = (sgb_pkg::RW'(k) <= cmd_s6.radius) ? cfg.coef[k] : '0;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		sgb_filter u_vfilt (
			.clk  (clk),
			.en   (en),
			.psum (vps_s2[c]),
			.wgt  (wv),
			.res  (vres[c])
		);
		sgb_filter u_hfilt (
			.clk  (clk),
			.en   (en),
			.psum (hps_s6[c]),
			.wgt  (wh),
			.res  (hres[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s8 && (cmd_s8.emit || cmd_s8.pass);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pix_q  <= cmd_s8.pass ? cmd_s8.pix : hres;
			out_fend_q <= cmd_s8.frame_end;
		end
	end

	assign px_out.valid     = out_valid_q;
	assign px_out.red_out   = out_pix_q[2];
	assign px_out.green_out = out_pix_q[1];
	assign px_out.blue_out  = out_pix_q[0];
	assign px_out.frame_end = out_fend_q;

endmodule

`default_nettype wire

// ===== dv/separable_gaussian_blur_rgb_top_tb.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb_top_tb
// Streams small RGB frames through the blur with random idle gaps and output
// stalls, and checks every output beat against a local line-buffer predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_gaussian_blur_rgb_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int RING           = sgb_pkg::RING;
	localparam int TAPS           = sgb_pkg::TAPS;
	localparam int MAX_WIDTH      = sgb_pkg::MAX_WIDTH;
	localparam int MAX_RADIUS     = sgb_pkg::MAX_RADIUS;
	localparam int PADDRW         = sgb_pkg::PADDRW;

	typedef struct packed {
		logic [23:0] pix;
		logic        fe;
	} blur_px_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDRW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	sgb_in_if  px_in ();
	sgb_out_if px_out ();

	separable_gaussian_blur_rgb_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.px_in   (px_in.sink),
		.px_out  (px_out.source)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Predictor state: line rings, vertical results and stream position.
	logic [23:0] line_ring [0:RING*MAX_WIDTH-1];
	logic [23:0] vert_hist [0:TAPS-1];
	logic [23:0] tap_buf   [0:TAPS-1];
	int unsigned reg_mirror [0:7];
	int unsigned in_x, in_y, frame_w, frame_h, frame_r;
	bit          last_fe;
	blur_px_t    blurred_q[$];

	int unsigned n_errors, n_beats, n_results, n_frames;
	int unsigned watchdog = 0;
	int unsigned stall_left;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		n_errors++;
	endtask

	function automatic int unsigned tap_weight(input int d);
		int unsigned a;
		a = (d < 0) ? -d : d;
		if (a == 0)
			return reg_mirror[sgb_pkg::REG_COEF_CENTER];
		return reg_mirror[int'(sgb_pkg::REG_COEF_CENTER) + ((a > MAX_RADIUS) ? MAX_RADIUS : a)];
	endfunction

	function automatic logic [23:0] apply_kernel(input int unsigned r);
		logic [23:0] res;
		int unsigned acc;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			acc = 0;
			for (int i = 0; i <= 2 * r; i++)
				acc += tap_weight(i - int'(r)) * tap_buf[i][ch*8 +: 8];
			acc = acc >> 16;
			if (acc > 255)
				acc = 255;
			res[ch*8 +: 8] = acc[7:0];
		end
		return res;
	endfunction

	task automatic predict_blur(input bit kind, input logic [23:0] pix);
		int unsigned total, p, q, qx, x;
		int t, c;
		bit real_px, emit;
		logic [23:0] res;
		blur_px_t item;
		last_fe = 1'b0;
		emit = 1'b0;
		q = 0;
		if (!kind && in_y == 0 && in_x == 0) begin
			frame_w = (reg_mirror[sgb_pkg::REG_FRAME_WIDTH] == 0) ? 1
				: reg_mirror[sgb_pkg::REG_FRAME_WIDTH];
			if (frame_w > MAX_WIDTH)
				frame_w = MAX_WIDTH;
			frame_h = (reg_mirror[sgb_pkg::REG_FRAME_HEIGHT] == 0) ? 1
				: reg_mirror[sgb_pkg::REG_FRAME_HEIGHT];
			frame_r = (reg_mirror[sgb_pkg::REG_BLUR_RADIUS] > MAX_RADIUS) ? MAX_RADIUS
				: reg_mirror[sgb_pkg::REG_BLUR_RADIUS];
		end
		total = frame_w * frame_h;
		p = in_y * frame_w + in_x;
		real_px = p < total;
		if (real_px && kind)
			return;
		if (!real_px && frame_r == 0)
			return;
		if (frame_r == 0) begin
			res = pix;
			q = p;
			emit = 1'b1;
		end else begin
			x = in_x;
			if (in_y >= frame_r) begin
				for (int d = -int'(frame_r); d <= int'(frame_r); d++) begin
					t = int'(in_y - frame_r) + d;
					if (t < 0)
						t = 0;
					if (t > int'(frame_h) - 1)
						t = int'(frame_h) - 1;
					if (real_px && t == int'(in_y))
						tap_buf[d + frame_r] = pix;
					else
						tap_buf[d + frame_r] = line_ring[(t % RING) * MAX_WIDTH + x];
				end
				for (int i = TAPS - 1; i > 0; i--)
					vert_hist[i] = vert_hist[i-1];
				vert_hist[0] = apply_kernel(frame_r);
			end
			if (real_px)
				line_ring[(in_y % RING) * MAX_WIDTH + x] = pix;
			if (in_y >= frame_r && p - frame_r * frame_w >= frame_r) begin
				q = p - frame_r * frame_w - frame_r;
				qx = q % frame_w;
				for (int d = -int'(frame_r); d <= int'(frame_r); d++) begin
					c = int'(qx) + d;
					if (c < 0)
						c = 0;
					if (c > int'(frame_w) - 1)
						c = int'(frame_w) - 1;
					tap_buf[d + frame_r] = vert_hist[int'(qx) + int'(frame_r) - c];
				end
				res = apply_kernel(frame_r);
				emit = 1'b1;
			end
		end
		in_x++;
		if (in_x >= frame_w) begin
			in_x = 0;
			in_y++;
		end
		if (emit) begin
			last_fe = (q == total - 1);
			item.pix = res;
			item.fe  = last_fe;
			blurred_q.insert(blurred_q.size(), item);
			if (last_fe) begin
				in_x = 0;
				in_y = 0;
			end
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called at a rising edge; returns at the edge where the beat is accepted.
	task automatic send_beat(input bit kind, input logic [23:0] pix);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			px_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		px_in.valid    <= 1'b1;
		px_in.kind     <= kind;
		px_in.red_in   <= pix[23:16];
		px_in.green_in <= pix[15:8];
		px_in.blue_in  <= pix[7:0];
		forever begin
			@(negedge clk);
			if (px_in.ready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		n_beats++;
		predict_blur(kind, pix);
	endtask

	// Setup cycle, access cycle, then psel drops before the next transfer.
	task automatic apb_write(input sgb_pkg::reg_idx_t idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDRW'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_mirror[idx] = value & ((idx == sgb_pkg::REG_FRAME_WIDTH) ? 32'hFFF
			: (idx == sgb_pkg::REG_FRAME_HEIGHT) ? 32'h1FFF
			: (idx == sgb_pkg::REG_BLUR_RADIUS) ? 32'h7 : 32'hFFFF);
		@(posedge clk);
	endtask

	// The back keeps working on commands that emit nothing, so give it time.
	task automatic wait_idle();
		px_in.valid <= 1'b0;
		while (blurred_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_frame(input int unsigned w, input int unsigned h,
		input int unsigned r, input int unsigned c0, input int unsigned c1,
		input int unsigned c2, input int unsigned c3, input int unsigned c4);
		wait_idle();
		apb_write(sgb_pkg::REG_FRAME_WIDTH, w);
		apb_write(sgb_pkg::REG_FRAME_HEIGHT, h);
		apb_write(sgb_pkg::REG_BLUR_RADIUS, r);
		apb_write(sgb_pkg::REG_COEF_CENTER, c0);
		apb_write(sgb_pkg::REG_COEF_1, c1);
		apb_write(sgb_pkg::REG_COEF_2, c2);
		apb_write(sgb_pkg::REG_COEF_3, c3);
		apb_write(sgb_pkg::REG_COEF_4, c4);
	endtask

	function automatic logic [23:0] rand_pix();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			default: return 24'($urandom());
		endcase
	endfunction

	// Sends one whole frame, then drain beats until the frame end is due.
	// With noise on, early drains and surplus pixels are mixed in.
	task automatic stream_frame(input int unsigned npix, input bit noisy);
		for (int unsigned i = 0; i < npix; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_beat(1'b1, 24'($urandom()));
			send_beat(1'b0, rand_pix());
		end
		while (!last_fe) begin
			if (noisy && $urandom_range(0, 3) == 0)
				send_beat(1'b0, 24'($urandom()));
			else
				send_beat(1'b1, 24'($urandom()));
		end
		n_frames++;
	endtask

	task automatic test_passthrough();
		program_frame(3, 2, 0, 65535, 0, 0, 0, 0);
		send_beat(1'b1, 24'h123456);
		send_beat(1'b0, 24'h000000);
		send_beat(1'b0, 24'hFFFFFF);
		send_beat(1'b1, 24'hABCDEF);
		send_beat(1'b0, 24'hFF0000);
		send_beat(1'b0, 24'h00FF00);
		send_beat(1'b0, 24'h0000FF);
		send_beat(1'b0, 24'h5AA55A);
		send_beat(1'b1, 24'h000000);
	endtask

	task automatic test_small_kernels();
		program_frame(4, 3, 1, 32768, 16384, 0, 0, 0);
		stream_frame(12, 1'b0);
		program_frame(5, 5, 2, 26000, 15000, 4768, 0, 0);
		stream_frame(25, 1'b1);
	endtask

	task automatic test_saturation();
		program_frame(3, 3, 4, 65535, 65535, 65535, 65535, 65535);
		stream_frame(9, 1'b0);
		program_frame(2, 2, 3, 0, 0, 0, 0, 0);
		stream_frame(4, 1'b0);
	endtask

	task automatic test_range_limits();
		program_frame(0, 0, 7, 40000, 12000, 700, 50, 1);
		stream_frame(1, 1'b1);
		program_frame(8, 2, 4, 20000, 12000, 8000, 2500, 1268);
		stream_frame(16, 1'b0);
		program_frame(1, 12, 4, 20000, 12000, 8000, 2500, 1268);
		stream_frame(12, 1'b0);
	endtask

	task automatic test_random_frames();
		int unsigned w, h, r, start;
		int unsigned c[5];
		start = n_beats;
		while (n_beats - start < 220) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			r = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
			for (int i = 0; i < 5; i++)
				c[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 65536 / (i + 2));
			program_frame(w, h, r, c[0], c[1], c[2], c[3], c[4]);
			stream_frame(w * h, $urandom_range(0, 2) == 0);
		end
	endtask

	// Output side stalls: mostly short, a few long, often none for a while.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_out.ready <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left > 0) begin
			px_out.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			px_out.ready <= 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2: stall_left <= $urandom_range(1, 3);
				3:       stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(15, 60) : 0;
				default: stall_left <= 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && px_out.valid && px_out.ready) begin
			blur_px_t want;
			if (blurred_q.size() == 0) begin
				$display("[%0t] output beat with nothing expected", $realtime);
				n_errors++;
			end else begin
				want = blurred_q.pop_front();
				n_results++;
				if (px_out.red_out !== want.pix[23:16])
					report_mismatch("red_out", 32'(px_out.red_out), 32'(want.pix[23:16]));
				if (px_out.green_out !== want.pix[15:8])
					report_mismatch("green_out", 32'(px_out.green_out), 32'(want.pix[15:8]));
				if (px_out.blue_out !== want.pix[7:0])
					report_mismatch("blue_out", 32'(px_out.blue_out), 32'(want.pix[7:0]));
				if (px_out.frame_end !== want.fe)
					report_mismatch("frame_end", 32'(px_out.frame_end), 32'(want.fe));
			end
		end
	end

	always @(posedge clk) begin
		if ((px_in.valid && px_in.ready) || (px_out.valid && px_out.ready) || psel)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", watchdog);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		px_in.valid    = 1'b0;
		px_in.kind     = 1'b0;
		px_in.red_in   = '0;
		px_in.green_in = '0;
		px_in.blue_in  = '0;
		n_errors       = 0;
		n_beats        = 0;
		n_results      = 0;
		n_frames       = 0;
		in_x = 0; in_y = 0;
		last_fe = 1'b0;
		reg_mirror = '{640, 480, 0, 65535, 0, 0, 0, 0};
		frame_w = 640; frame_h = 480; frame_r = 0;
		foreach (line_ring[i])
			line_ring[i] = '0;
		foreach (vert_hist[i])
			vert_hist[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_small_kernels();
		test_saturation();
		test_range_limits();
		test_random_frames();
		wait_idle();

		$display("Sent %0d input beats over %0d frames; %0d blurred pixels checked.",
			n_beats, n_frames, n_results);
		$display("Radii 0 to 7, widths 0 to 12 and heights 0 to 12 were exercised.");
		if (n_errors == 0 && blurred_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors, %0d results never arrived", n_errors, blurred_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/sgb_pkg.sv
src/sgb_if.sv
src/sgb_ram.sv
src/sgb_filter.sv
src/sgb_queue.sv
src/sgb_front.sv
src/sgb_back.sv
src/separable_gaussian_blur_rgb_top.sv
dv/separable_gaussian_blur_rgb_top_tb.sv
